// ----- src/dlpd_pkg.sv -----
// Shared constants and types for the debounced long-press detector.
// No dependencies; imported by dlpd_channel and the core top level.
package dlpd_pkg;

  // Number of push inputs polled together
  localparam int NUM_INPUTS = 2;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 16;
  localparam int HOLD_W     = 24;
  localparam int FIRED_W    = $clog2(NUM_INPUTS + 1);

  // APB register map: register index is paddr[ADDR_W-1:2]
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_W  = ADDR_W - 2;

  localparam logic [REG_W-1:0] REG_DEBOUNCE_TIME = 2'd0;
  localparam logic [REG_W-1:0] REG_HOLD_TIME     = 2'd1;
  localparam logic [REG_W-1:0] REG_ACTIVE_HIGH   = 2'd2;
  localparam logic [REG_W-1:0] REG_INPUT_ENABLE  = 2'd3;

  // Reset values of the configuration registers
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET    = 16'd50;
  localparam logic [HOLD_W-1:0]     HOLD_RESET        = 24'd3000;
  localparam logic [NUM_INPUTS-1:0] ACTIVE_HIGH_RESET = 2'd2;
  localparam logic [NUM_INPUTS-1:0] ENABLE_RESET      = 2'd1;

  // Per-input status after one poll
  typedef struct packed {
    logic pressed;  // debounced pressed level
    logic fire;     // press reached the hold time in this poll
    logic holding;  // pressed and not yet fired
  } chan_status_t;

endpackage

// ----- src/dlpd_channel.sv -----
// One input channel: polarity, debounce and hold timing for a single pin.
// Depends on dlpd_pkg for widths and the channel status struct.
module dlpd_channel (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             update,
  input  logic                             started,
  input  logic                             enable,
  input  logic                             level,
  input  logic                             active_high,
  input  logic [dlpd_pkg::TIME_W-1:0]      now,
  input  logic [dlpd_pkg::DEBOUNCE_W-1:0]  debounce_time,
  input  logic [dlpd_pkg::HOLD_W-1:0]      hold_time,
  input  logic                             fire_any,
  output dlpd_pkg::chan_status_t           status
);
  import dlpd_pkg::*;

  logic              last_raw;
  logic [TIME_W-1:0] change_time;
  logic              debounced;
  logic [TIME_W-1:0] press_time;
  logic              already_fired;

  logic              raw;
  logic              last_raw_next;
  logic [TIME_W-1:0] change_time_next;
  logic              debounced_next;
  logic [TIME_W-1:0] press_time_next;
  logic              fired_pre;
  logic              already_fired_next;
  logic              stable_long;
  logic              hold_done;
  logic              fire;

  assign raw         = (level == active_high);
  assign stable_long = (now - change_time) >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_time};

  always_comb begin
    last_raw_next    = last_raw;
    change_time_next = change_time;
    debounced_next   = debounced;
    press_time_next  = press_time;
    fired_pre        = already_fired;
    if (!enable) begin
      last_raw_next    = 1'b0;
      change_time_next = now;
      debounced_next   = 1'b0;
      fired_pre        = 1'b0;
    end else if (!started) begin
      // capture only
      last_raw_next    = raw;
      change_time_next = now;
      debounced_next   = 1'b0;
      fired_pre        = 1'b0;
    end else if (raw != last_raw) begin
      last_raw_next    = raw;
      change_time_next = now;
    end else if (raw != debounced && stable_long) begin
      debounced_next = raw;
      if (raw) begin
        press_time_next = change_time;
        fired_pre       = 1'b0;
      end
    end
  end

  assign hold_done = (now - press_time_next) >= {{(TIME_W-HOLD_W){1'b0}}, hold_time};
  assign fire      = enable && started && debounced_next && !fired_pre && hold_done;

  // mark every pressed input once any input fires
  assign already_fired_next = fired_pre | fire | (fire_any & debounced_next);

  assign status.pressed = debounced_next;
  assign status.fire    = fire;
  assign status.holding = debounced_next & ~already_fired_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw      <= 1'b0;
      change_time   <= '0;
      debounced     <= 1'b0;
      already_fired <= 1'b0;
    end else if (update) begin
      last_raw      <= last_raw_next;
      change_time   <= change_time_next;
      debounced     <= debounced_next;
      already_fired <= already_fired_next;
    end
  end

  // press start time, only read while debounced is set
  always_ff @(posedge clk) begin
    if (update) begin
      press_time <= press_time_next;
    end
  end

endmodule

// ----- src/debounced_long_press_detector_core.sv -----
// Debounced long-press detector core: poll input register, per-channel
// debounce/hold logic, result register and APB configuration registers.
// Depends on dlpd_pkg and dlpd_channel.
//
// Pipeline: an accepted request waits in the poll register until the result
// register is empty or being drained, and then its result is registered.
// Throughput: one poll per cycle while out_stall is low; the per-channel time
// compares are the only work between the poll register and the result register.
// Reset: synchronous; clears channel state, the started flag, both
// handshake stages and loads the configuration reset values.
module debounced_long_press_detector_core (
  input  logic                             clk,
  input  logic                             rst,
  // poll channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dlpd_pkg::TIME_W-1:0]      now,
  input  logic [dlpd_pkg::NUM_INPUTS-1:0]  raw_levels,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dlpd_pkg::FIRED_W-1:0]     fired_source,
  output logic                             hold_in_progress,
  output logic [dlpd_pkg::NUM_INPUTS-1:0]  pressed_levels,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dlpd_pkg::ADDR_W-1:0]      paddr,
  input  logic [dlpd_pkg::DATA_W-1:0]      pwdata,
  output logic [dlpd_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import dlpd_pkg::*;

  // Configuration registers
  logic [DEBOUNCE_W-1:0] debounce_time;
  logic [HOLD_W-1:0]     hold_time;
  logic [NUM_INPUTS-1:0] active_high_mask;
  logic [NUM_INPUTS-1:0] input_enable_mask;

  logic             cfg_write;
  logic [REG_W-1:0] reg_idx;

  // Poll register
  logic                  in_full;
  logic [TIME_W-1:0]     in_now;
  logic [NUM_INPUTS-1:0] in_levels;

  logic started;
  logic accept;
  logic move;

  chan_status_t          chan_status [NUM_INPUTS];
  logic [NUM_INPUTS-1:0] fire_vec;
  logic [NUM_INPUTS-1:0] pressed_vec;
  logic [NUM_INPUTS-1:0] holding_vec;
  logic                  fire_any;
  logic [FIRED_W-1:0]    fired_next;

  // ---------------------------------------------------------------------
  // APB registers: always ready, write on the access phase
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time     <= DEBOUNCE_RESET;
      hold_time         <= HOLD_RESET;
      active_high_mask  <= ACTIVE_HIGH_RESET;
      input_enable_mask <= ENABLE_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_DEBOUNCE_TIME: debounce_time     <= pwdata[DEBOUNCE_W-1:0];
        REG_HOLD_TIME:     hold_time         <= pwdata[HOLD_W-1:0];
        REG_ACTIVE_HIGH:   active_high_mask  <= pwdata[NUM_INPUTS-1:0];
        REG_INPUT_ENABLE:  input_enable_mask <= pwdata[NUM_INPUTS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE_TIME: prdata = {{(DATA_W-DEBOUNCE_W){1'b0}}, debounce_time};
      REG_HOLD_TIME:     prdata = {{(DATA_W-HOLD_W){1'b0}}, hold_time};
      REG_ACTIVE_HIGH:   prdata = {{(DATA_W-NUM_INPUTS){1'b0}}, active_high_mask};
      REG_INPUT_ENABLE:  prdata = {{(DATA_W-NUM_INPUTS){1'b0}}, input_enable_mask};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: the poll register advances into the result register
  // whenever the result register is empty or being drained.
  // ---------------------------------------------------------------------
  assign move     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !move;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  // hold the poll payload until it moves on
  always_ff @(posedge clk) begin
    if (accept) begin
      in_now    <= now;
      in_levels <= raw_levels;
    end
  end

  // The first poll after reset only captures levels
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (move) begin
      started <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Per-input channels, all evaluated in parallel on the held poll
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_chan
    dlpd_channel u_chan (
      .clk           (clk),
      .rst           (rst),
      .update        (move),
      .started       (started),
      .enable        (input_enable_mask[g]),
      .level         (in_levels[g]),
      .active_high   (active_high_mask[g]),
      .now           (in_now),
      .debounce_time (debounce_time),
      .hold_time     (hold_time),
      .fire_any      (fire_any),
      .status        (chan_status[g])
    );
    assign fire_vec[g]    = chan_status[g].fire;
    assign pressed_vec[g] = chan_status[g].pressed;
    assign holding_vec[g] = chan_status[g].holding;
  end

  assign fire_any = |fire_vec;

  // report the lowest-numbered firing input, one-based
  always_comb begin
    fired_next = '0;
    for (int i = NUM_INPUTS - 1; i >= 0; i--) begin
      if (fire_vec[i]) begin
        fired_next = FIRED_W'(i + 1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      fired_source     <= fired_next;
      hold_in_progress <= |holding_vec;
      pressed_levels   <= pressed_vec;
    end
  end

`ifndef SYNTH
  // A fired input is always among the pressed ones
  a_fired_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && (fired_source != '0) |-> (pressed_levels != '0))
    else $error("fired source reported with no pressed input");

  // The reported source is zero or a real input index
  a_fired_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fired_source <= FIRED_W'(NUM_INPUTS)))
    else $error("fired source out of range");

  // The first poll after reset yields an all-zero result
  a_first_poll: assert property (@(posedge clk) disable iff (rst)
    move && !started |=> (fired_source == '0) && !hold_in_progress &&
                         (pressed_levels == '0))
    else $error("first poll after reset produced a non-empty result");

  // Disabled inputs never show as pressed
  a_disabled_clear: assert property (@(posedge clk) disable iff (rst)
    move |=> ((pressed_levels & ~input_enable_mask) == '0))
    else $error("disabled input reported as pressed");
`endif

endmodule
